>>> design/qirl_pkg.sv
// Shared types and constants for the quadtree index range lookup block.
// No dependencies; every other file in this folder imports it.
`timescale 1ns / 1ps

package qirl_pkg;

    localparam int INDEX_DEPTH_DEF = 8192;
    localparam int MAX_LEVEL_DEF   = 6;

    localparam int KEY_W    = 13;
    localparam int WADDR_W  = 13;
    localparam int WORD_W   = 32;
    localparam int COUNT_W  = 14;
    localparam int MSB_W    = 4;
    localparam int LEVEL_W  = 3;
    // Walk addresses stay below 7300 for any 13-bit key
    localparam int WALK_W   = 16;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic               operation;
        logic [WADDR_W-1:0] word_address;
        logic [WORD_W-1:0]  word_value;
        logic [KEY_W-1:0]   quad_key;
    } in_item_t;

    typedef struct packed {
        logic [WORD_W-1:0] tile_offset;
        logic [WORD_W-1:0] tile_length;
        logic              out_of_range;
    } out_item_t;

    // Classified command handed from the front to the back
    typedef struct packed {
        logic               operation;
        logic [WADDR_W-1:0] word_address;
        logic [WORD_W-1:0]  word_value;
        logic [KEY_W-1:0]   quad_key;
        logic [LEVEL_W-1:0] level;
        logic               key_bad;
    } cmd_t;

    // Queue status seen by the front and the back
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

>>> design/qirl_front.sv
// Front stage: accepts input transfers, finds the quadkey level and flags bad keys.
// Depends on qirl_pkg; pushes classified commands into qirl_queue.
`timescale 1ns / 1ps

module qirl_front #(
    parameter int MAX_LEVEL = qirl_pkg::MAX_LEVEL_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  qirl_pkg::in_item_t in_data,
    input  qirl_pkg::q_status_t q_status,
    output logic              push,
    output qirl_pkg::cmd_t    push_data
);
    import qirl_pkg::*;

    logic               valid_reg;
    logic               valid_next;
    cmd_t               cmd_reg;
    cmd_t               cmd_next;
    logic [MSB_W-1:0]   msb;
    logic [LEVEL_W-1:0] lvl;
    logic               accept;

    // Highest set bit of the key gives floor(log2(key))
    always_comb
    begin
        msb = '0;
        for (int b = 0; b < KEY_W; b++)
        begin
            if (in_data.quad_key[b])
            begin
                msb = MSB_W'(b);
            end
        end
    end

    assign lvl = LEVEL_W'(msb >> 1);

    assign in_stall = valid_reg && q_status.full;
    assign accept   = in_valid && !in_stall;
    assign push     = valid_reg && !q_status.full;

    always_comb
    begin
        cmd_next              = cmd_reg;
        cmd_next.operation    = in_data.operation;
        cmd_next.word_address = in_data.word_address;
        cmd_next.word_value   = in_data.word_value;
        cmd_next.quad_key     = in_data.quad_key;
        cmd_next.level        = lvl;
        cmd_next.key_bad      = (in_data.quad_key < KEY_W'(4)) ||
                                ({1'b0, lvl} > (LEVEL_W + 1)'(MAX_LEVEL));
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (push)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd_next;
        end
    end

    assign push_data = cmd_reg;

endmodule

>>> design/qirl_queue.sv
// Short command queue between the front and the back stage.
// Depends on qirl_pkg for the command type and depth constants.
`timescale 1ns / 1ps

module qirl_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  qirl_pkg::cmd_t     push_data,
    input  logic               pop,
    output qirl_pkg::cmd_t     pop_data,
    output qirl_pkg::q_status_t status
);
    import qirl_pkg::*;

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg;
    logic [QCNT_W-1:0] cnt_next;
    logic              do_push;
    logic              do_pop;

    assign status.full  = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.empty = (cnt_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_data     = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> design/qirl_back.sv
// Back stage: index memory, tree-walk sequencer and output register.
// Depends on qirl_pkg; pops commands from qirl_queue.
`timescale 1ns / 1ps

module qirl_back #(
    parameter int INDEX_DEPTH = qirl_pkg::INDEX_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [qirl_pkg::COUNT_W-1:0] word_count,
    input  qirl_pkg::cmd_t              cmd,
    input  qirl_pkg::q_status_t         q_status,
    output logic                        pop,
    output logic                        out_valid,
    input  logic                        out_stall,
    output qirl_pkg::out_item_t         out_data
);
    import qirl_pkg::*;

    localparam int AW = (INDEX_DEPTH > 1) ? $clog2(INDEX_DEPTH) : 1;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_ROOT = 5'b00010,
        S_WALK = 5'b00100,
        S_WAIT = 5'b01000,
        S_EMIT = 5'b10000
    } state_t;

    logic [WORD_W-1:0] mem [INDEX_DEPTH];
    logic [WORD_W-1:0] mem_q_reg;
    logic [AW-1:0]     rd_addr;
    logic              mem_we;

    state_t             state_reg,  state_next;
    logic [WALK_W-1:0]  base_reg,   base_next;
    logic [WALK_W-1:0]  pos_reg,    pos_next;
    logic [WALK_W-1:0]  tsize_reg,  tsize_next;
    logic [KEY_W-1:0]   q_reg,      q_next;
    logic [1:0]         d_reg,      d_next;
    logic [LEVEL_W-1:0] steps_reg,  steps_next;
    logic [LEVEL_W-1:0] roots_reg,  roots_next;
    logic [WORD_W-1:0]  sum_reg,    sum_next;
    logic [WORD_W-1:0]  len_reg,    len_next;
    logic               zero_reg,   zero_next;
    logic               oor_reg,    oor_next;
    logic               rd_add_reg, rd_add_next;
    logic               out_valid_reg, out_valid_next;
    out_item_t          out_reg,    out_next;

    logic [COUNT_W-1:0] limit;
    logic [WALK_W-1:0]  limit_w;
    logic [WALK_W-1:0]  wbase;
    logic [1:0]         digit;

    assign limit   = (32'(word_count) > 32'(INDEX_DEPTH)) ? COUNT_W'(INDEX_DEPTH) : word_count;
    assign limit_w = WALK_W'(limit);
    assign wbase   = base_reg + pos_reg;
    assign digit   = q_reg[1:0];

    always_comb
    begin
        state_next     = state_reg;
        base_next      = base_reg;
        pos_next       = pos_reg;
        tsize_next     = tsize_reg;
        q_next         = q_reg;
        d_next         = d_reg;
        steps_next     = steps_reg;
        roots_next     = roots_reg;
        sum_next       = sum_reg + (rd_add_reg ? mem_q_reg : '0);
        len_next       = len_reg;
        zero_next      = zero_reg;
        oor_next       = oor_reg;
        rd_add_next    = 1'b0;
        rd_addr        = '0;
        mem_we         = 1'b0;
        pop            = 1'b0;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && out_stall;

        case (state_reg)
            S_IDLE:
            begin
                if (!q_status.empty)
                begin
                    pop = 1'b1;
                    if (cmd.operation == OP_WRITE)
                    begin
                        mem_we = (32'(cmd.word_address) < 32'(INDEX_DEPTH));
                    end
                    else
                    begin
                        sum_next   = '0;
                        len_next   = '0;
                        base_next  = '0;
                        pos_next   = WALK_W'(1);
                        tsize_next = WALK_W'(5);
                        q_next     = cmd.quad_key;
                        d_next     = '0;
                        steps_next = cmd.level;
                        roots_next = cmd.level - 1'b1;
                        zero_next  = 1'b0;
                        oor_next   = 1'b0;
                        if (word_count == '0)
                        begin
                            zero_next  = 1'b1;
                            state_next = S_EMIT;
                        end
                        else if (cmd.key_bad)
                        begin
                            zero_next  = 1'b1;
                            oor_next   = 1'b1;
                            state_next = S_EMIT;
                        end
                        else if (cmd.level == LEVEL_W'(1))
                        begin
                            state_next = S_WALK;
                        end
                        else
                        begin
                            state_next = S_ROOT;
                        end
                    end
                end
            end
            S_ROOT:
            begin
                if (base_reg >= limit_w)
                begin
                    zero_next  = 1'b1;
                    oor_next   = 1'b1;
                    state_next = S_EMIT;
                end
                else
                begin
                    rd_addr     = AW'(base_reg);
                    rd_add_next = 1'b1;
                    base_next   = base_reg + tsize_reg;
                    tsize_next  = {tsize_reg[WALK_W-3:0], 2'b01};
                    roots_next  = roots_reg - 1'b1;
                    if (roots_reg == LEVEL_W'(1))
                    begin
                        state_next = S_WALK;
                    end
                end
            end
            S_WALK:
            begin
                if ((wbase + WALK_W'(4)) > limit_w)
                begin
                    zero_next  = 1'b1;
                    oor_next   = 1'b1;
                    state_next = S_EMIT;
                end
                else if (d_reg < digit)
                begin
                    rd_addr     = AW'(wbase + WALK_W'(d_reg));
                    rd_add_next = 1'b1;
                    d_next      = d_reg + 1'b1;
                end
                else if (steps_reg == LEVEL_W'(1))
                begin
                    rd_addr    = AW'(wbase + WALK_W'(digit));
                    state_next = S_WAIT;
                end
                else
                begin
                    pos_next   = {pos_reg[WALK_W-3:0] + (WALK_W-2)'(digit), 2'b01};
                    q_next     = q_reg >> 2;
                    steps_next = steps_reg - 1'b1;
                    d_next     = '0;
                end
            end
            S_WAIT:
            begin
                len_next   = mem_q_reg;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next        = 1'b1;
                    out_next.tile_offset  = zero_reg ? '0 : sum_reg;
                    out_next.tile_length  = zero_reg ? '0 : len_reg;
                    out_next.out_of_range = oor_reg;
                    state_next            = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            rd_add_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            rd_add_reg    <= rd_add_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg  <= base_next;
        pos_reg   <= pos_next;
        tsize_reg <= tsize_next;
        q_reg     <= q_next;
        d_reg     <= d_next;
        steps_reg <= steps_next;
        roots_reg <= roots_next;
        sum_reg   <= sum_next;
        len_reg   <= len_next;
        zero_reg  <= zero_next;
        oor_reg   <= oor_next;
        out_reg   <= out_next;
    end

    // Index memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[AW'(cmd.word_address)] <= cmd.word_value;
        end
        mem_q_reg <= mem[rd_addr];
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

>>> design/quadtree_index_range_lookup.sv
// Top level of the quadtree index range lookup: config register, front, queue, back.
// Depends on qirl_pkg, qirl_front, qirl_queue and qirl_back.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+----------------------------------
//  in      | input     | in_valid / in_stall    | in_data  (operation, address, value, key)
//  out     | output    | out_valid / out_stall  | out_data (offset, length, out_of_range)
//  cfg     | input     | cfg_wr_en              | cfg_wr_data (index word count)
//
// A write passes through the front register and the queue and reaches the index memory
// when the idle back pops it. A query holds the back while it walks the level trees:
// every index word passes through the single read port. Reset clears control state and
// the word count, not the index memory. The front takes transfers until the two-entry
// queue and its register are full; a stalled output holds the back in its emit step.
`timescale 1ns / 1ps

module quadtree_index_range_lookup #(
    parameter int INDEX_DEPTH = qirl_pkg::INDEX_DEPTH_DEF,
    parameter int MAX_LEVEL   = qirl_pkg::MAX_LEVEL_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [qirl_pkg::COUNT_W-1:0] cfg_wr_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  qirl_pkg::in_item_t          in_data,
    output logic                        out_valid,
    input  logic                        out_stall,
    output qirl_pkg::out_item_t         out_data
);
    import qirl_pkg::*;

    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               push;
    cmd_t               push_data;
    logic               pop;
    cmd_t               pop_data;
    q_status_t          q_status;

    // Hold the word count until the next configuration write
    assign count_next = cfg_wr_en ? cfg_wr_data : count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Front: register the transfer, find the level, flag short and deep keys
    qirl_front #(
        .MAX_LEVEL (MAX_LEVEL)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .q_status  (q_status),
        .push      (push),
        .push_data (push_data)
    );

    // Decouple the front from the walk sequencer
    qirl_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .status    (q_status)
    );

    // Back: store words, walk the level trees, drive the output register
    qirl_back #(
        .INDEX_DEPTH (INDEX_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .word_count (count_reg),
        .cmd        (pop_data),
        .q_status   (q_status),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

endmodule
